// File: rtl/lsh_pkg.sv
// lsh_pkg: shared types and constants of the 3x3 Laplacian sharpening core.
// No dependencies; imported by the channel interfaces and every rtl module but lsh_ram.
package lsh_pkg;

   localparam int PIX_W       = 8;
   localparam int CFG_W       = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int LINE_WORD_W = 2 * PIX_W;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   // floor(s/3) for s <= 765 as (s * 683) >> 11
   localparam int RGB_SUM_W   = 10;
   localparam int GRAY_PROD_W = 20;
   localparam int GRAY_RECIP  = 683;
   localparam int GRAY_SHIFT  = 11;

   // kernel weights
   localparam int CENTRE_WEIGHT = 40;
   localparam int EDGE_WEIGHT   = 10;
   localparam int KSUM_W        = 14;
   localparam int PIX_MAX       = 255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // per-item control carried from the scan stage to the kernel stage
   typedef struct packed {
      logic emit;
      logic last;
      logic up_ok;
      logic dn_ok;
      logic lf_ok;
      logic rt_ok;
   } item_flags_type;

endpackage

// File: rtl/lsh_chan_if.sv
// Valid/ready channel interfaces of the sharpening core: RGB request, filtered response.
// Depends on lsh_pkg for the pixel width.
interface lsh_req_if import lsh_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface lsh_rsp_if import lsh_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] filtered_pixel;
   logic             last_of_frame;

   modport source (output valid, filtered_pixel, last_of_frame, input ready);
   modport sink   (input valid, filtered_pixel, last_of_frame, output ready);
endinterface

// File: rtl/laplacian_sharpen_3x3_core.sv
// laplacian_sharpen_3x3_core: streaming 3x3 Laplacian sharpening of gray pixels.
// Depends on lsh_pkg, lsh_chan_if, lsh_ram, lsh_scan and lsh_kernel.
//
//   channel  dir  handshake      payload
//   req_chan in   valid/ready    red, green, blue
//   rsp_chan out  valid/ready    filtered_pixel, last_of_frame
//   csr_*    in   csr_wr_en      csr_index, csr_wr_data
//
// One beat per cycle unless stalled; beats pass the kernel stage, then rsp regs.
// Both line buffers share one RAM word, read on accept and written back as the
// beat leaves the kernel stage; a same-column read in that cycle is forwarded.
// Synchronous reset; the line RAM has no clearing pass.
// req_chan stalls only while a result waits in the output register and the
// next result is ready to follow it.
module laplacian_sharpen_3x3_core import lsh_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   lsh_req_if.sink              req_chan,
   lsh_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic accept, out_free, s1_adv;

   logic [COL_W-1:0] scan_col;
   logic [PIX_W-1:0] scan_gray;
   item_flags_type   scan_flags;

   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_gray_ff;
   item_flags_type   s1_flags_ff;

   logic                   fwd_hit_ff;
   logic [LINE_WORD_W-1:0] fwd_word_ff;
   logic [LINE_WORD_W-1:0] ram_rd_data, line_word, wr_word;

   logic [PIX_W-1:0] kern_pixel;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_last_ff;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && (!s1_flags_ff.emit || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   lsh_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .red         (req_chan.red),
      .green       (req_chan.green),
      .blue        (req_chan.blue),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .col         (scan_col),
      .gray        (scan_gray),
      .flags       (scan_flags)
   );

   // word layout: {two rows above, row above}
   assign line_word = fwd_hit_ff ? fwd_word_ff : ram_rd_data;
   assign wr_word   = {line_word[PIX_W-1:0], s1_gray_ff};

   lsh_ram #(
      .WIDTH (LINE_WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (scan_col),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept || (s1_valid_ff && !s1_adv);
         if (accept) begin
            fwd_hit_ff <= s1_adv && (s1_col_ff == scan_col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= scan_col;
         s1_gray_ff  <= scan_gray;
         s1_flags_ff <= scan_flags;
         fwd_word_ff <= wr_word;
      end
   end

   lsh_kernel u_kernel (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_adv),
      .top_in   (line_word[LINE_WORD_W-1:PIX_W]),
      .mid_in   (line_word[PIX_W-1:0]),
      .gray_in  (s1_gray_ff),
      .flags    (s1_flags_ff),
      .pixel    (kern_pixel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_flags_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_flags_ff.emit) begin
         rsp_pixel_ff <= kern_pixel;
         rsp_last_ff  <= s1_flags_ff.last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_pixel = rsp_pixel_ff;
   assign rsp_chan.last_of_frame  = rsp_last_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && s1_flags_ff.emit && rsp_valid_ff && !rsp_chan.ready)
      else $error("request stalled without a blocked result");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat lost before the kernel stage");

   a_result_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_flags_ff.emit |=>
         rsp_chan.valid && (rsp_chan.filtered_pixel == $past(kern_pixel)))
      else $error("kernel result not presented");

endmodule

// File: rtl/lsh_ram.sv
// lsh_ram: generic simple dual-port RAM, one write and one registered read port.
// Read returns the old word on a same-address write. No dependencies.
module lsh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lsh_scan.sv
// lsh_scan: frame size registers, raster position counters, gray conversion and
// per-item edge flags. Depends on lsh_pkg.
module lsh_scan import lsh_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [PIX_W-1:0]     red,
   input  logic [PIX_W-1:0]     green,
   input  logic [PIX_W-1:0]     blue,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data,
   output logic [COL_W-1:0]     col,
   output logic [PIX_W-1:0]     gray,
   output item_flags_type       flags
);

   localparam int MAX_A = (CFG_W > COL_W) ? CFG_W : COL_W;
   localparam int CMP_W = ((MAX_A > ROW_W) ? MAX_A : ROW_W) + 1;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [CMP_W-1:0]       w_ext, h_ext, w_eff, h_eff, c_ext, r_ext;
   logic [RGB_SUM_W-1:0]   rgb_sum;
   logic [GRAY_PROD_W-1:0] gray_prod;

   always_comb begin
      w_ext = CMP_W'(width_ff);
      h_ext = CMP_W'(height_ff);
      if (w_ext == '0) begin
         w_eff = CMP_W'(1);
      end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (h_ext == '0) begin
         h_eff = CMP_W'(1);
      end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
         h_eff = CMP_W'(MAX_HEIGHT);
      end else begin
         h_eff = h_ext;
      end
      c_ext = CMP_W'(col_ff);
      r_ext = CMP_W'(row_ff);
   end

   always_comb begin
      rgb_sum   = RGB_SUM_W'(red) + RGB_SUM_W'(green) + RGB_SUM_W'(blue);
      gray_prod = GRAY_PROD_W'(rgb_sum) * GRAY_PROD_W'(GRAY_RECIP);
      if (r_ext < h_eff) begin
         gray = gray_prod[GRAY_SHIFT +: PIX_W];
      end else begin
         gray = '0;
      end
   end

   // centre lies one row up and one column left; at column 0 it wraps to the
   // end of the row two up
   always_comb begin
      flags.emit = (r_ext >= CMP_W'(2)) || ((r_ext == CMP_W'(1)) && (c_ext != '0));
      flags.last = (r_ext == h_eff + CMP_W'(1)) && (c_ext == '0);
      if (c_ext != '0) begin
         flags.up_ok = r_ext >= CMP_W'(2);
         flags.dn_ok = r_ext < h_eff;
         flags.lf_ok = c_ext >= CMP_W'(2);
         flags.rt_ok = 1'b1;
      end else begin
         flags.up_ok = r_ext >= CMP_W'(3);
         flags.dn_ok = r_ext <= h_eff;
         flags.lf_ok = w_eff >= CMP_W'(2);
         flags.rt_ok = 1'b0;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wr_data;
               col_in   = '0;
               row_in   = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wr_data;
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (advance) begin
         if (flags.last) begin
            col_in = '0;
            row_in = '0;
         end else if (c_ext + CMP_W'(1) >= w_eff) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign col = col_ff;

endmodule

// File: rtl/lsh_kernel.sv
// lsh_kernel: 3x3 window registers and the clamped Laplacian sum.
// Depends on lsh_pkg.
module lsh_kernel import lsh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [PIX_W-1:0] top_in,
   input  logic [PIX_W-1:0] mid_in,
   input  logic [PIX_W-1:0] gray_in,
   input  item_flags_type   flags,
   output logic [PIX_W-1:0] pixel
);

   // only the taps the cross-shaped kernel touches are kept
   logic [PIX_W-1:0] top_last_ff, mid_last_ff, mid_prev_ff, gray_last_ff;

   logic [KSUM_W-1:0] pos_sum, neg_sum, diff;

   always_comb begin
      pos_sum = KSUM_W'(mid_last_ff) * KSUM_W'(CENTRE_WEIGHT);
      neg_sum = '0;
      if (flags.up_ok) begin
         neg_sum = neg_sum + KSUM_W'(top_last_ff) * KSUM_W'(EDGE_WEIGHT);
      end
      if (flags.dn_ok) begin
         neg_sum = neg_sum + KSUM_W'(gray_last_ff) * KSUM_W'(EDGE_WEIGHT);
      end
      if (flags.lf_ok) begin
         neg_sum = neg_sum + KSUM_W'(mid_prev_ff) * KSUM_W'(EDGE_WEIGHT);
      end
      if (flags.rt_ok) begin
         neg_sum = neg_sum + KSUM_W'(mid_in) * KSUM_W'(EDGE_WEIGHT);
      end
      diff = pos_sum - neg_sum;
      if (neg_sum >= pos_sum) begin
         pixel = '0;
      end else if (diff > KSUM_W'(PIX_MAX)) begin
         pixel = PIX_W'(PIX_MAX);
      end else begin
         pixel = diff[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_last_ff  <= '0;
         mid_last_ff  <= '0;
         mid_prev_ff  <= '0;
         gray_last_ff <= '0;
      end else if (shift_en) begin
         top_last_ff  <= top_in;
         mid_last_ff  <= mid_in;
         mid_prev_ff  <= mid_last_ff;
         gray_last_ff <= gray_in;
      end
   end

endmodule

// File: verif/tb_laplacian_sharpen_3x3_core.sv
// Self-checking testbench of laplacian_sharpen_3x3_core: RGB beats in, filtered gray beats out,
// each result compared with a built-in line-buffer filter predictor, under random idling.
// Depends on lsh_pkg, lsh_chan_if and the core rtl.
`timescale 1ns / 100ps

module tb_laplacian_sharpen_3x3_core;
   import lsh_pkg::*;

   localparam int unsigned MAX_W         = 1024;
   localparam int unsigned MAX_H         = 1024;
   localparam int unsigned RAND_BEATS    = 500;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned REPORT_MAX    = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             last;
   } sharp_out_type;

   typedef struct packed {
      rgb_type          px;
      logic             typed;
      logic [PIX_W-1:0] want;
   } unit_frame_type;

   typedef enum int {FILL_NOISE, FILL_SMOOTH, FILL_BINARY} fill_kind_type;

   logic clock;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wr_data;

   lsh_req_if req_bus ();
   lsh_rsp_if rsp_bus ();

   laplacian_sharpen_3x3_core #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   logic [PIX_W-1:0] row_above     [0:MAX_W-1];
   logic [PIX_W-1:0] row_two_above [0:MAX_W-1];
   logic [PIX_W-1:0] win           [0:8];
   int unsigned      scan_col;
   int unsigned      scan_row;

   sharp_out_type due_pixels [$];
   int unsigned   mism_cnt;
   int unsigned   beats_sent;
   int unsigned   req_idle_pct;
   int unsigned   rsp_idle_pct;
   bit            hold_req;
   int unsigned   hold_left;

   // single-pixel frames: the result is 40 * gray, clamped
   unit_frame_type unit_frames [0:7] = '{
      '{'{8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, 8'd255},
      '{'{8'd1,   8'd1,   8'd1},   1'b1, 8'd40},
      '{'{8'd2,   8'd0,   8'd0},   1'b1, 8'd0},
      '{'{8'd6,   8'd6,   8'd6},   1'b1, 8'd240},
      '{'{8'd8,   8'd7,   8'd6},   1'b1, 8'd255},
      '{'{8'd0,   8'd255, 8'd0},   1'b0, 8'd0},
      '{'{8'd0,   8'd0,   8'd255}, 1'b0, 8'd0}
   };

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
      if (v == '0) return 1;
      if (v > lim) return lim;
      return int'(v);
   endfunction

   function automatic int unsigned frame_beats();
      int unsigned w;
      w = eff_dim(cfg_width, MAX_W);
      return w * eff_dim(cfg_height, MAX_H) + w + 1;
   endfunction

   task automatic sharpen_predict(input rgb_type px, output bit emit, output sharp_out_type res);
      int unsigned w, h, row, col, cr, cc, k, rgb_sum;
      logic [PIX_W-1:0] gray, top, mid;
      int acc;
      bit last;
      w = eff_dim(cfg_width, MAX_W);
      h = eff_dim(cfg_height, MAX_H);
      row = scan_row;
      col = (scan_col >= w) ? 0 : scan_col;
      gray = '0;
      if (row < h) begin
         rgb_sum = int'(px.red) + int'(px.green) + int'(px.blue);
         gray = PIX_W'(rgb_sum / 3);
      end
      top = row_two_above[col];
      mid = row_above[col];
      row_two_above[col] = mid;
      row_above[col] = gray;
      for (k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = gray;
      emit = (row >= 2) || (row == 1 && col >= 1);
      last = (row == h + 1) && (col == 0);
      if (last) begin
         scan_row = 0;
         scan_col = 0;
      end else if (col + 1 >= w) begin
         scan_col = 0;
         scan_row = row + 1;
      end else begin
         scan_col = col + 1;
      end
      res = '0;
      if (emit) begin
         if (col >= 1) begin
            cr = row - 1;
            cc = col - 1;
         end else begin
            cr = row - 2;
            cc = w - 1;
         end
         acc = CENTRE_WEIGHT * int'(win[4]);
         if (cr > 0)     acc -= EDGE_WEIGHT * int'(win[1]);
         if (cr + 1 < h) acc -= EDGE_WEIGHT * int'(win[7]);
         if (cc > 0)     acc -= EDGE_WEIGHT * int'(win[3]);
         if (cc + 1 < w) acc -= EDGE_WEIGHT * int'(win[5]);
         if (acc < 0) acc = 0;
         if (acc > PIX_MAX) acc = PIX_MAX;
         res.pix  = acc[PIX_W-1:0];
         res.last = last;
      end
   endtask

   function automatic rgb_type pick_rgb(input fill_kind_type fill, input int unsigned base);
      rgb_type p;
      case (fill)
         FILL_SMOOTH: begin
            p.red   = PIX_W'(base + $urandom_range(0, 3));
            p.green = PIX_W'(base + $urandom_range(0, 3));
            p.blue  = PIX_W'(base + $urandom_range(0, 3));
         end
         FILL_BINARY: begin
            p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
         end
         default: begin
            p.red   = PIX_W'($urandom_range(0, 255));
            p.green = PIX_W'($urandom_range(0, 255));
            p.blue  = PIX_W'($urandom_range(0, 255));
         end
      endcase
      return p;
   endfunction

   // valid stays high across back-to-back beats
   task automatic send_beat(input rgb_type px, input bit typed = 1'b0,
                            input logic [PIX_W-1:0] typed_pix = '0);
      bit emit;
      sharp_out_type res;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= px.red;
      req_bus.green <= px.green;
      req_bus.blue  <= px.blue;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      sharpen_predict(px, emit, res);
      if (emit) begin
         if (typed) res = '{pix: typed_pix, last: 1'b1};
         due_pixels.push_back(res);
      end
   endtask

   task automatic send_run(input fill_kind_type fill, input int unsigned n);
      int unsigned base;
      base = $urandom_range(0, 252);
      repeat (n) send_beat(pick_rgb(fill, base));
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (due_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: begin
            cfg_width = val;
            scan_col = 0;
            scan_row = 0;
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = val;
            scan_col = 0;
            scan_row = 0;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned budget);
      logic [CFG_W-1:0] w, h;
      int unsigned pick, sel, n;
      fill_kind_type fill;
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
         w = 11'd1;
         h = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
      end else if (pick == 1) begin
         w = CFG_W'($urandom_range(1025, 2047));
         h = '0;
      end else if (pick < 5) begin
         w = '0;
         h = CFG_W'($urandom_range(0, 6));
      end else if (pick < 9) begin
         w = CFG_W'($urandom_range(1, 3));
         h = CFG_W'($urandom_range(1, 12));
      end else begin
         w = CFG_W'($urandom_range(2, 16));
         h = CFG_W'($urandom_range(1, 10));
      end
      if ($urandom_range(0, 5) != 0) begin
         settle();
         if ($urandom_range(0, 7) == 0) begin
            csr_write(CSR_SPARE_3, CFG_W'($urandom_range(0, 2047)));
         end
         sel = $urandom_range(0, 3);
         if (sel != 1) csr_write(CSR_IMAGE_WIDTH, w);
         if (sel != 0) csr_write(CSR_IMAGE_HEIGHT, h);
      end
      fill = fill_kind_type'($urandom_range(0, 2));
      n = frame_beats() * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > budget) n = budget;
      send_run(fill, n);
   endtask

   task automatic check_result(input logic [PIX_W-1:0] pix, input logic last);
      sharp_out_type want;
      if (due_pixels.size() == 0) begin
         mism_cnt++;
         if (mism_cnt <= REPORT_MAX)
            $display("unexpected beat: pix=%0d last=%0b", pix, last);
      end else begin
         want = due_pixels.pop_front();
         if (pix !== want.pix || last !== want.last) begin
            mism_cnt++;
            if (mism_cnt <= REPORT_MAX)
               $display("mismatch: expected pix=%0d last=%0b, got pix=%0d last=%0b",
                        want.pix, want.last, pix, last);
         end
      end
   endtask

   // result side: check, then choose ready for the next edge
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_result(rsp_bus.filtered_pixel, rsp_bus.last_of_frame);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      #8_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int unsigned k, rand_start;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.red   <= '0;
      req_bus.green <= '0;
      req_bus.blue  <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_IMAGE_WIDTH;
      csr_wr_data   <= '0;
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      for (k = 0; k < MAX_W; k++) begin
         row_above[k] = '0;
         row_two_above[k] = '0;
      end
      for (k = 0; k < 9; k++) win[k] = '0;
      scan_col     = 0;
      scan_row     = 0;
      mism_cnt     = 0;
      beats_sent   = 0;
      hold_req     = 1'b0;
      hold_left    = 0;
      req_idle_pct = 26;
      rsp_idle_pct = 75;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: past the first row of a 640-wide frame
      send_run(FILL_NOISE, 660);
      settle();

      // zero width and height give one-pixel frames; spare index must not restart one
      csr_write(CSR_IMAGE_WIDTH, 11'd0);
      csr_write(CSR_IMAGE_HEIGHT, 11'd0);
      for (k = 0; k < 8; k++) begin
         send_beat(unit_frames[k].px);
         if (k == 3) begin
            settle();
            csr_write(CSR_SPARE_2, 11'h7ff);
         end
         send_beat(pick_rgb(FILL_NOISE, 0));
         send_beat(pick_rgb(FILL_NOISE, 0), unit_frames[k].typed, unit_frames[k].want);
      end
      settle();

      // long receiver hold-off with the sender still offering beats
      csr_write(CSR_IMAGE_WIDTH, 11'd4);
      csr_write(CSR_IMAGE_HEIGHT, 11'd12);
      hold_req = 1'b1;
      send_run(FILL_NOISE, frame_beats());

      rand_start = beats_sent;
      while (beats_sent - rand_start < RAND_BEATS) begin
         if (beats_sent - rand_start < RAND_BEATS / 3) begin
            req_idle_pct = 26;
            rsp_idle_pct = 75;
         end else if (beats_sent - rand_start < 2 * RAND_BEATS / 3) begin
            req_idle_pct = 75;
            rsp_idle_pct = 26;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         random_phase(RAND_BEATS - (beats_sent - rand_start));
      end

      req_bus.valid <= 1'b0;
      while (due_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mism_cnt == 0 && due_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
